[design/cbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_pkg
// Shared types and constants of the clipped blending pixel store.
// ----------------------------------------------------------------------------
package cbps_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned PIX_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 9;

  localparam logic [8:0] ALPHA_ONE = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    WSEL_ZERO  = 2'd0,
    WSEL_FILL  = 2'd1,
    WSEL_BLEND = 2'd2
  } wsel_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic [8:0]         blend_alpha;
  } req_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       hit;
  } rsp_t;

  typedef struct packed {
    logic  load_item;
    logic  locate;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  asel_cnt;
    logic  rd_en;
    logic  wr_en;
    wsel_e wsel;
    logic  load_blend;
    logic  load_rsp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic       full_alpha;
    logic       prod_zero;
    logic       init_last;
    logic       fill_last;
  } stat_t;

endpackage

[design/clipped_blending_pixel_store.sv]
`timescale 1ns / 1ps
// A get result strobes on done_o, registered, once its start transfer has passed
// LOCATE, ACCESS and DATA. The single RAM port takes a new transfer only in IDLE;
// a replacing or clipped put runs LOCATE, ACCESS; a get adds DATA; a blending put
// adds DATA, WRITE (read, blend, write back); a clear adds FILL over the frame,
// one pixel a cycle. Reset: frame size goes to 0 and a clearing pass zeroes all
// MAX_WIDTH*MAX_HEIGHT pixels (65536 by default) with busy_o high.
// ----------------------------------------------------------------------------
// clipped_blending_pixel_store
// RGB frame buffer with clipped, alpha-blended puts, gets and frame clear.
// ----------------------------------------------------------------------------
module clipped_blending_pixel_store #(
  parameter int unsigned MAX_WIDTH  = cbps_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cbps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cbps_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           start_i,
  input  cbps_pkg::req_t                 req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output cbps_pkg::rsp_t                 rsp_o
);
  import cbps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cbps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (req_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  cbps_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .rsp_o     (rsp_o)
  );

`ifndef SYNTH
  a_get_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.kind == KIND_GET |-> ##4 done_o)
    else $error("get transfer without result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.hit |->
      rsp_o.read_red == 8'd0 && rsp_o.read_green == 8'd0 && rsp_o.read_blue == 8'd0)
    else $error("miss with nonzero colour");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside get completion");
`endif

endmodule

[design/cbps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cbps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/cbps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_ctrl
// Sequencer for put, get and clear, plus the clearing pass after reset.
// ----------------------------------------------------------------------------
module cbps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      kind_i,
  input  cbps_pkg::stat_t stat_i,
  output cbps_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import cbps_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOCATE = 7'b0000100,
    S_ACCESS = 7'b0001000,
    S_DATA   = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_FILL   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '{default: '0, wsel: WSEL_FILL};
    unique case (state_q)
      S_INIT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wsel     = WSEL_ZERO;
        cmd_o.asel_cnt = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          if (kind_i == KIND_PUT || kind_i == KIND_GET || kind_i == KIND_CLEAR) begin
            state_d = S_LOCATE;
          end
        end
      end
      S_LOCATE: begin
        cmd_o.locate  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = S_ACCESS;
      end
      S_ACCESS: begin
        state_d = S_IDLE;
        if (stat_i.kind == KIND_CLEAR) begin
          if (!stat_i.prod_zero) begin
            state_d = S_FILL;
          end
        end else if (stat_i.kind == KIND_GET) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DATA;
        end else if (stat_i.kind == KIND_PUT && stat_i.hit) begin
          if (stat_i.full_alpha) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (stat_i.kind == KIND_GET) begin
          cmd_o.load_rsp = 1'b1;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.load_blend = 1'b1;
          state_d          = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WSEL_BLEND;
        state_d     = S_IDLE;
      end
      S_FILL: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.asel_cnt = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

[design/cbps_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_dpath
// Frame size registers, clipping, address multiply, blend and pixel RAM.
// ----------------------------------------------------------------------------
module cbps_dpath #(
  parameter int unsigned MAX_WIDTH  = cbps_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cbps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cbps_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  cbps_pkg::req_t                 req_i,
  input  cbps_pkg::cmd_t                 cmd_i,
  output cbps_pkg::stat_t                stat_o,
  output cbps_pkg::rsp_t                 rsp_o
);
  import cbps_pkg::*;

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW    = WW + HW;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMPW  = 16;
  localparam logic [CW-1:0] CntLast = CW'(DEPTH - 1);

  function automatic logic [7:0] mix(input logic [7:0] old, input logic [7:0] nw,
                                     input logic [8:0] a);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    diff = $signed({2'b00, nw}) - $signed({2'b00, old});
    prod = 20'(diff) * 20'($signed({1'b0, a}));
    return old + prod[15:8];
  endfunction

  logic [WW-1:0]    width_q;
  logic [HW-1:0]    height_q;
  req_t             item_q;
  logic             hit_q;
  logic [PW-1:0]    prod_q;
  logic [CW-1:0]    cnt_q;
  logic [PIX_W-1:0] blend_q;
  rsp_t             rsp_q;

  logic [HW-1:0]    mul_b;
  logic             hit_d;
  logic [AW-1:0]    pix_addr;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] ram_rdata;

  // frame size, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        width_q <= (32'(cfg_data_i) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data_i);
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        height_q <= (32'(cfg_data_i) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
      end
    end
  end

  assign hit_d = !item_q.pos_x[15] && !item_q.pos_y[15]
               && (CMPW'(item_q.pos_x[14:0]) < CMPW'(width_q))
               && (CMPW'(item_q.pos_y[14:0]) < CMPW'(height_q));

  assign mul_b = (item_q.kind == KIND_CLEAR) ? height_q : item_q.pos_y[HW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= req_i;
    end
    if (cmd_i.locate) begin
      hit_q  <= hit_d;
      prod_q <= PW'(width_q) * PW'(mul_b);
    end
    if (cmd_i.load_blend) begin
      blend_q <= {mix(ram_rdata[23:16], item_q.in_red,   item_q.blend_alpha),
                  mix(ram_rdata[15:8],  item_q.in_green, item_q.blend_alpha),
                  mix(ram_rdata[7:0],   item_q.in_blue,  item_q.blend_alpha)};
    end
    if (cmd_i.load_rsp) begin
      rsp_q.read_red   <= hit_q ? ram_rdata[23:16] : 8'd0;
      rsp_q.read_green <= hit_q ? ram_rdata[15:8]  : 8'd0;
      rsp_q.read_blue  <= hit_q ? ram_rdata[7:0]   : 8'd0;
      rsp_q.hit        <= hit_q;
    end
  end

  // sweep counter for the reset pass and frame clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign pix_addr = AW'(PW'(item_q.pos_x[WW-1:0]) + prod_q);
  assign ram_addr = cmd_i.asel_cnt ? cnt_q[AW-1:0] : pix_addr;

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_ZERO:  ram_wdata = '0;
      WSEL_FILL:  ram_wdata = {item_q.in_red, item_q.in_green, item_q.in_blue};
      WSEL_BLEND: ram_wdata = blend_q;
      default:    ram_wdata = '0;
    endcase
  end

  cbps_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .re_i   (cmd_i.rd_en),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign stat_o.kind       = item_q.kind;
  assign stat_o.hit        = hit_q;
  assign stat_o.full_alpha = (item_q.blend_alpha >= ALPHA_ONE);
  assign stat_o.prod_zero  = (prod_q == '0);
  assign stat_o.init_last  = (cnt_q == CntLast);
  assign stat_o.fill_last  = (cnt_q == CW'(CW'(prod_q) - CW'(1)));

  assign rsp_o = rsp_q;

endmodule

[sim/clipped_blending_pixel_store_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_blending_pixel_store_test
// Self-checking bench for the pixel store. A queue-fed driver issues put, get
// and clear commands with random idle bursts while a monitor keeps a shadow
// frame buffer, predicts every get read and compares it field by field. The
// frame size is changed between phases, the extremes and overflow included.
// ----------------------------------------------------------------------------
module clipped_blending_pixel_store_test;
  import cbps_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 start_i = 1'b0;
  req_t                 req_i = '0;
  logic                 busy_o;
  logic                 done_o;
  rsp_t                 rsp_o;

  logic [23:0] pixel_model [0:STORE_DEPTH-1];
  int          frame_w = 0;
  int          frame_h = 0;
  req_t        pending_cmds [$];
  rsp_t        expected_reads [$];
  rsp_t        want_read;
  int          cmds_queued = 0;
  int          cmds_taken = 0;
  int          idle_left = 0;
  bit          calm = 1'b0;
  bit          took = 1'b0;
  int          hot_x = 0;
  int          hot_y = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          n_puts = 0;
  int          n_gets = 0;
  int          n_hits = 0;
  int          n_clears = 0;
  int          n_sizes = 0;

  clipped_blending_pixel_store dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] mix_channel(input logic [7:0] old_c, input logic [7:0] new_c,
                                             input logic [8:0] a);
    int unsigned sum;
    sum = 32'(old_c) * (32'(ALPHA_ONE) - 32'(a)) + 32'(new_c) * 32'(a);
    return sum[15:8];
  endfunction

  // shadow frame buffer update for one accepted command
  function automatic void apply_command(input req_t cmd);
    int          xi, yi, spot, n, i;
    logic [8:0]  a;
    logic [23:0] old;
    rsp_t        rd;
    xi = int'(cmd.pos_x);
    yi = int'(cmd.pos_y);
    spot = -1;
    if (xi >= 0 && yi >= 0 && xi < frame_w && yi < frame_h) begin
      spot = xi + frame_w * yi;
      if (spot >= STORE_DEPTH) spot = -1;
    end
    a = (cmd.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cmd.blend_alpha;
    case (cmd.kind)
      KIND_PUT: begin
        n_puts++;
        if (spot >= 0) begin
          old = pixel_model[spot];
          if (a == ALPHA_ONE) begin
            pixel_model[spot] = {cmd.in_red, cmd.in_green, cmd.in_blue};
          end else begin
            pixel_model[spot] = {mix_channel(old[23:16], cmd.in_red, a),
                                 mix_channel(old[15:8], cmd.in_green, a),
                                 mix_channel(old[7:0], cmd.in_blue, a)};
          end
        end
      end
      KIND_GET: begin
        n_gets++;
        rd = '0;
        if (spot >= 0) begin
          {rd.read_red, rd.read_green, rd.read_blue} = pixel_model[spot];
          rd.hit = 1'b1;
          n_hits++;
        end
        expected_reads.push_back(rd);
      end
      KIND_CLEAR: begin
        n_clears++;
        n = frame_w * frame_h;
        for (i = 0; i < n; i++) pixel_model[i] = {cmd.in_red, cmd.in_green, cmd.in_blue};
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || took) begin
      if (idle_left > 0) begin
        start_i <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_cmds.size() != 0) begin
        req_i <= pending_cmds.pop_front();
        start_i <= 1'b1;
        if (!calm && $urandom_range(3) == 0) idle_left <= $urandom_range(19, 1);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took <= start_i && !busy_o;
      if (done_o) begin
        if (expected_reads.size() == 0) begin
          $error("read result with no get outstanding");
          errors++;
        end else begin
          want_read = expected_reads.pop_front();
          if (rsp_o.read_red !== want_read.read_red) begin
            $error("read_red: expected %0d, got %0d", want_read.read_red, rsp_o.read_red);
            errors++;
          end
          if (rsp_o.read_green !== want_read.read_green) begin
            $error("read_green: expected %0d, got %0d", want_read.read_green, rsp_o.read_green);
            errors++;
          end
          if (rsp_o.read_blue !== want_read.read_blue) begin
            $error("read_blue: expected %0d, got %0d", want_read.read_blue, rsp_o.read_blue);
            errors++;
          end
          if (rsp_o.hit !== want_read.hit) begin
            $error("hit: expected %0d, got %0d", want_read.hit, rsp_o.hit);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        apply_command(req_i);
        cmds_taken++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic queue_cmd(input logic [1:0] kind, input int x, input int y,
                           input logic [23:0] colour, input int alpha);
    req_t c;
    c.kind = kind;
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    {c.in_red, c.in_green, c.in_blue} = colour;
    c.blend_alpha = alpha[8:0];
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // wait until every command is taken, every read is back and the block is idle
  task automatic settle();
    do @(negedge clk_i);
    while (cmds_taken != cmds_queued || expected_reads.size() != 0 || busy_o);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_FRAME_WIDTH;
    cfg_data_i <= w[8:0];
    @(negedge clk_i);
    cfg_idx_i <= REG_FRAME_HEIGHT;
    cfg_data_i <= h[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frame_w = (w > int'(DEF_MAX_WIDTH)) ? int'(DEF_MAX_WIDTH) : w;
    frame_h = (h > int'(DEF_MAX_HEIGHT)) ? int'(DEF_MAX_HEIGHT) : h;
    n_sizes++;
  endtask

  task automatic run_random(input int count, input bit clears_ok);
    int         i, pick, sel, x, y, alpha;
    logic [1:0] kind;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) kind = KIND_PUT;
      else if (pick < 88 || (pick < 94 && !clears_ok)) kind = KIND_GET;
      else if (pick < 94) kind = KIND_CLEAR;
      else kind = KIND_UNUSED;
      // revisit a recent put spot, stay near the frame, or go anywhere
      sel = $urandom_range(9);
      if (sel < 3) begin
        x = hot_x;
        y = hot_y;
      end else if (sel < 9) begin
        x = int'($urandom_range(frame_w + 1)) - 1;
        y = int'($urandom_range(frame_h + 1)) - 1;
        if (kind == KIND_PUT) begin
          hot_x = x;
          hot_y = y;
        end
      end else begin
        x = int'($urandom_range(65535)) - 32768;
        y = int'($urandom_range(65535)) - 32768;
      end
      sel = $urandom_range(9);
      if (sel < 4) alpha = int'(ALPHA_ONE);
      else if (sel < 5) alpha = $urandom_range(511, 257);
      else alpha = $urandom_range(255);
      queue_cmd(kind, x, y, 24'($urandom), alpha);
    end
    settle();
  endtask

  initial begin
    int k;
    for (k = 0; k < STORE_DEPTH; k++) pixel_model[k] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // empty frame after reset
    queue_cmd(KIND_GET, 0, 0, 24'h000000, 0);
    queue_cmd(KIND_PUT, 0, 0, 24'hFFFFFF, 256);
    queue_cmd(KIND_CLEAR, 0, 0, 24'h123456, 0);
    queue_cmd(KIND_UNUSED, 0, 0, 24'hFFFFFF, 511);
    settle();

    // width overflow saturates to the maximum
    set_frame(511, 2);
    queue_cmd(KIND_PUT, 0, 0, 24'hFF8001, 256);
    queue_cmd(KIND_GET, 0, 0, 24'h000000, 0);
    queue_cmd(KIND_PUT, 255, 1, 24'hAA550F, 511);
    queue_cmd(KIND_GET, 255, 1, 24'h000000, 0);
    queue_cmd(KIND_PUT, 255, 1, 24'hFFFFFF, 0);
    queue_cmd(KIND_PUT, 255, 1, 24'h00FF80, 255);
    queue_cmd(KIND_GET, 255, 1, 24'h000000, 0);
    queue_cmd(KIND_PUT, 0, 0, 24'h000000, 128);
    queue_cmd(KIND_PUT, 1, 0, 24'h7F7F7F, 257);
    queue_cmd(KIND_GET, 0, 0, 24'h000000, 0);
    queue_cmd(KIND_GET, 1, 0, 24'h000000, 0);
    queue_cmd(KIND_GET, 256, 0, 24'h000000, 0);
    queue_cmd(KIND_GET, 0, 2, 24'h000000, 0);
    queue_cmd(KIND_GET, -1, 0, 24'h000000, 0);
    queue_cmd(KIND_GET, 0, -1, 24'h000000, 0);
    queue_cmd(KIND_GET, -32768, 32767, 24'h000000, 0);
    queue_cmd(KIND_PUT, 32767, -32768, 24'hFFFFFF, 256);
    queue_cmd(KIND_UNUSED, 5, 1, 24'hFFFFFF, 256);
    queue_cmd(KIND_CLEAR, 0, 0, 24'h563412, 0);
    queue_cmd(KIND_GET, 255, 1, 24'h000000, 0);
    settle();

    set_frame(1, 1);
    run_random(30, 1'b1);
    set_frame(16, 16);
    run_random(70, 1'b1);
    set_frame(256, 256);
    run_random(30, 1'b0);
    queue_cmd(KIND_CLEAR, 0, 0, 24'($urandom), 0);
    run_random(30, 1'b0);
    set_frame(0, 7);
    run_random(25, 1'b1);
    set_frame(5, 0);
    run_random(15, 1'b1);
    set_frame(300, 1);
    run_random(50, 1'b1);
    set_frame(1, 511);
    run_random(50, 1'b1);
    set_frame(3, 40);
    run_random(60, 1'b1);
    for (k = 0; k < 4; k++) begin
      set_frame($urandom_range(24, 1), $urandom_range(24, 1));
      run_random(60, 1'b1);
    end
    calm = 1'b1;
    set_frame(9, 5);
    run_random(60, 1'b1);

    $display("covered %0d puts, %0d gets (%0d inside the frame) and %0d clears",
             n_puts, n_gets, n_hits, n_clears);
    $display("over %0d frame sizes, %0d mismatches", n_sizes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
